// ===== rtl/rlpd_pkg.sv =====
// Shared types, constants and helper functions for the run-length pixel decoder.
package rlpd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] COUNT_MASK = 8'h7F;
   localparam logic [7:0] RUN_FLAG   = 8'h80;

   typedef enum logic [2:0] {
      FMT_GRAY8    = 3'd0,
      FMT_GRAY16   = 3'd1,
      FMT_RGB555   = 3'd2,
      FMT_ARGB1555 = 3'd3,
      FMT_RGB565   = 3'd4,
      FMT_BGR24    = 3'd5,
      FMT_BGRA32   = 3'd6,
      FMT_BGRX32   = 3'd7
   } fmt_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT     = 2'd0,
      CSR_RUN_LENGTH_CODED = 2'd1,
      CSR_PIXEL_TOTAL      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [31:0] pixel;
      fmt_type     fmt;
      logic [7:0]  rep_count;
      logic        done;
      logic        overflow;
   } cmd_type;

   function automatic logic [2:0] fmt_bytes(input fmt_type f);
      logic [2:0] n;
      case (f)
         FMT_GRAY8:                           n = 3'd1;
         FMT_GRAY16, FMT_RGB555,
         FMT_ARGB1555, FMT_RGB565:            n = 3'd2;
         FMT_BGR24:                           n = 3'd3;
         default:                             n = 3'd4;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] x);
      return {x, x[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] x);
      return {x, x[5:4]};
   endfunction

endpackage

// ===== rtl/rlpd_front.sv =====
// Front end: configuration registers, packet parsing, pixel gathering and counting.
module rlpd_front
   import rlpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   input  logic                req_valid,
   input  logic                req_accept,
   input  logic [7:0]          req_data_byte,
   output logic                push,
   output cmd_type             push_cmd
);

   fmt_type                  pixel_format_ff;
   logic                     run_length_coded_ff;
   logic [31:0]              pixel_total_ff;

   logic                     expecting_header_ff, expecting_header_in;
   logic                     packet_is_run_ff, packet_is_run_in;
   logic [7:0]               packet_left_ff, packet_left_in;
   logic [1:0]               byte_pos_ff, byte_pos_in;
   logic [31:0]              gathered_ff, gathered_in;
   logic [COUNT_WIDTH-1:0]   emitted_ff, emitted_in;
   logic                     halted_ff, halted_in;

   logic [COUNT_WIDTH-1:0]   limit;
   logic [31:0]              gathered_new;
   logic                     pix_done;
   logic [7:0]               hdr_count;
   logic                     hdr_over;
   logic                     do_emit;
   logic [7:0]               emit_rep;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff     <= FMT_BGR24;
         run_length_coded_ff <= 1'b0;
         pixel_total_ff      <= 32'd1;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT:     pixel_format_ff     <= fmt_type'(csr_write_data[2:0]);
            CSR_RUN_LENGTH_CODED: run_length_coded_ff <= csr_write_data[0];
            CSR_PIXEL_TOTAL:      pixel_total_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign limit        = pixel_total_ff[COUNT_WIDTH-1:0];
   assign gathered_new = gathered_ff | (32'(req_data_byte) << {byte_pos_ff, 3'b000});
   assign pix_done     = ({1'b0, byte_pos_ff} + 3'd1) >= fmt_bytes(pixel_format_ff);
   assign hdr_count    = (req_data_byte & COUNT_MASK) + 8'd1;
   assign hdr_over     = ({1'b0, emitted_ff} + (COUNT_WIDTH+1)'(hdr_count))
                         > {1'b0, limit};

   always_comb begin
      expecting_header_in = expecting_header_ff;
      packet_is_run_in    = packet_is_run_ff;
      packet_left_in      = packet_left_ff;
      byte_pos_in         = byte_pos_ff;
      gathered_in         = gathered_ff;
      emitted_in          = emitted_ff;
      halted_in           = halted_ff;
      do_emit             = 1'b0;
      emit_rep            = 8'd1;
      push                = 1'b0;
      push_cmd            = '0;

      if (req_valid && req_accept && !halted_ff) begin
         if (!run_length_coded_ff) begin
            if (emitted_ff >= limit) begin
               halted_in         = 1'b1;
               push              = 1'b1;
               push_cmd.overflow = 1'b1;
            end else begin
               gathered_in = gathered_new;
               byte_pos_in = byte_pos_ff + 2'd1;
               do_emit     = pix_done;
            end
         end else if (expecting_header_ff) begin
            if (hdr_over) begin
               halted_in         = 1'b1;
               push              = 1'b1;
               push_cmd.overflow = 1'b1;
            end else begin
               packet_is_run_in    = (req_data_byte & RUN_FLAG) != 8'd0;
               packet_left_in      = hdr_count;
               expecting_header_in = 1'b0;
               byte_pos_in         = 2'd0;
               gathered_in         = '0;
            end
         end else begin
            gathered_in = gathered_new;
            byte_pos_in = byte_pos_ff + 2'd1;
            if (pix_done) begin
               do_emit = 1'b1;
               if (packet_is_run_ff) begin
                  emit_rep            = packet_left_ff;
                  packet_left_in      = 8'd0;
                  expecting_header_in = 1'b1;
               end else begin
                  packet_left_in = packet_left_ff - 8'd1;
                  if (packet_left_ff == 8'd1) begin
                     expecting_header_in = 1'b1;
                  end
               end
            end
         end
      end

      if (do_emit) begin
         emitted_in         = emitted_ff + COUNT_WIDTH'(emit_rep);
         push               = 1'b1;
         push_cmd.pixel     = gathered_new;
         push_cmd.fmt       = pixel_format_ff;
         push_cmd.rep_count = emit_rep;
         push_cmd.done      = emitted_in == limit;
         gathered_in        = '0;
         byte_pos_in        = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_header_ff <= 1'b1;
         packet_is_run_ff    <= 1'b0;
         packet_left_ff      <= '0;
         byte_pos_ff         <= '0;
         gathered_ff         <= '0;
         emitted_ff          <= '0;
         halted_ff           <= 1'b0;
      end else begin
         expecting_header_ff <= expecting_header_in;
         packet_is_run_ff    <= packet_is_run_in;
         packet_left_ff      <= packet_left_in;
         byte_pos_ff         <= byte_pos_in;
         gathered_ff         <= gathered_in;
         emitted_ff          <= emitted_in;
         halted_ff           <= halted_in;
      end
   end

endmodule

// ===== rtl/rlpd_queue.sv =====
// Short command queue between the front end and the pixel unpacker.
module rlpd_queue
   import rlpd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   do_pop;

   assign full       = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rlpd_back.sv =====
// Back end: unpacks queued pixels to RGBA into the result register.
module rlpd_back
   import rlpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_red_level,
   output logic [7:0]   rsp_green_level,
   output logic [7:0]   rsp_blue_level,
   output logic [7:0]   rsp_alpha_level,
   output logic [15:0]  rsp_wide_gray,
   output logic [7:0]   rsp_repeat_count,
   output logic         rsp_image_done,
   output logic         rsp_overflow_error
);

   logic         valid_ff;
   logic [7:0]   red_ff, green_ff, blue_ff, alpha_ff, rep_ff;
   logic [15:0]  wide_ff;
   logic         done_ff, over_ff;

   logic [7:0]   red_in, green_in, blue_in, alpha_in;
   logic [15:0]  wide_in;
   logic [31:0]  p;

   assign pop = head_valid && (!valid_ff || !rsp_stall);
   assign p   = head_cmd.pixel;

   always_comb begin
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      alpha_in = 8'hFF;
      wide_in  = 16'd0;
      case (head_cmd.fmt)
         FMT_GRAY8: begin
            red_in   = p[7:0];
            green_in = p[7:0];
            blue_in  = p[7:0];
         end
         FMT_GRAY16: begin
            wide_in  = p[15:0];
            red_in   = p[15:8];
            green_in = p[15:8];
            blue_in  = p[15:8];
         end
         FMT_RGB555, FMT_ARGB1555: begin
            blue_in  = widen5(p[4:0]);
            green_in = widen5(p[9:5]);
            red_in   = widen5(p[14:10]);
            if (head_cmd.fmt == FMT_ARGB1555) begin
               alpha_in = p[15] ? 8'hFF : 8'h00;
            end
         end
         FMT_RGB565: begin
            blue_in  = widen5(p[4:0]);
            green_in = widen6(p[10:5]);
            red_in   = widen5(p[15:11]);
         end
         FMT_BGR24: begin
            blue_in  = p[7:0];
            green_in = p[15:8];
            red_in   = p[23:16];
         end
         default: begin
            blue_in  = p[7:0];
            green_in = p[15:8];
            red_in   = p[23:16];
            if (head_cmd.fmt == FMT_BGRA32) begin
               alpha_in = p[31:24];
            end
         end
      endcase
      if (head_cmd.overflow) begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
         alpha_in = 8'd0;
         wide_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         wide_ff  <= wide_in;
         rep_ff   <= head_cmd.rep_count;
         done_ff  <= head_cmd.done;
         over_ff  <= head_cmd.overflow;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_red_level      = red_ff;
   assign rsp_green_level    = green_ff;
   assign rsp_blue_level     = blue_ff;
   assign rsp_alpha_level    = alpha_ff;
   assign rsp_wide_gray      = wide_ff;
   assign rsp_repeat_count   = rep_ff;
   assign rsp_image_done     = done_ff;
   assign rsp_overflow_error = over_ff;

endmodule

// ===== rtl/run_length_pixel_decoder_top.sv =====
// Top level of the run-length pixel decoder.
// Takes one image data byte per cycle while the queue is not full. The front end
// parses packet headers, gathers pixel bytes and keeps the pixel count; finished pixels
// pass through a two-entry queue to the unpacker, whose output register holds the result.
// Each result is queued, then registered by the unpacker. Bytes are taken while a
// result waits, until the queue fills. Configure through the csr_ port only while idle.
// After an overflow result the block drops every byte until reset.
module run_length_pixel_decoder_top
   import rlpd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_write_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_red_level,
   output logic [7:0]   rsp_green_level,
   output logic [7:0]   rsp_blue_level,
   output logic [7:0]   rsp_alpha_level,
   output logic [15:0]  rsp_wide_gray,
   output logic [7:0]   rsp_repeat_count,
   output logic         rsp_image_done,
   output logic         rsp_overflow_error
);

   logic     push, full, pop, head_valid;
   cmd_type  push_cmd, head_cmd;

   assign req_stall = full;

   rlpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_accept       (!full),
      .req_data_byte    (req_data_byte),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   rlpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   rlpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_level      (rsp_red_level),
      .rsp_green_level    (rsp_green_level),
      .rsp_blue_level     (rsp_blue_level),
      .rsp_alpha_level    (rsp_alpha_level),
      .rsp_wide_gray      (rsp_wide_gray),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_image_done     (rsp_image_done),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule
